@@ rtl/hot_trace_frequency_table_defines.svh @@
// Assertion macros used by the hot trace frequency table checker.
`ifndef HOT_TRACE_FREQUENCY_TABLE_DEFINES_SVH
`define HOT_TRACE_FREQUENCY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define HTFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("htft: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HTFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("htft: next-cycle check failed");

`endif

@@ rtl/htft_pkg.sv @@
// Shared constants, types and codes of the hot trace frequency table.
package htft_pkg;
   localparam int MaxTraceLen  = 64;
   localparam int TableEntries = 64;

   localparam int PcW        = 64;
   localparam int OutcomeW   = 3;
   localparam int IndexW     = 6;
   localparam int CountW     = 32;
   localparam int LengthW    = 7;
   localparam int LenW       = $clog2(MaxTraceLen + 1);
   localparam int PosW       = $clog2(MaxTraceLen);
   localparam int IdxW       = (TableEntries > 1) ? $clog2(TableEntries) : 1;
   localparam int StoreDepth = TableEntries * MaxTraceLen;
   localparam int StoreAddrW = $clog2(StoreDepth);

   typedef logic [OutcomeW-1:0] outcome_type;
   localparam outcome_type OUT_OPEN  = 3'd0;
   localparam outcome_type OUT_NEW   = 3'd1;
   localparam outcome_type OUT_MATCH = 3'd2;
   localparam outcome_type OUT_FULL  = 3'd3;
   localparam outcome_type OUT_LONG  = 3'd4;

   typedef enum logic [1:0] {
      CMD_OPEN   = 2'd0,
      CMD_LONG   = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [PcW-1:0]  hash;
      logic [LenW-1:0] length;
   } cmd_type;

   typedef struct packed {
      logic            free_trace;
      logic [PosW-1:0] addr;
   } trace_rd_req_type;

   typedef struct packed {
      outcome_type        outcome;
      logic [IndexW-1:0]  entry_index;
      logic [CountW-1:0]  trace_count;
      logic [LengthW-1:0] trace_length;
   } result_type;

   typedef struct packed {
      logic [PcW-1:0]    hash;
      logic [LenW-1:0]   length;
      logic [CountW-1:0] count;
   } header_type;
endpackage

@@ rtl/hot_trace_frequency_table.sv @@
// Top level of the hot trace frequency table.
//
//   Channel   Direction  Handshake          Fields
//   req_      in         push / full        req_pc, req_is_control, req_target
//   rsp_      out        pop / empty        rsp_outcome, rsp_entry_index,
//                                           rsp_trace_count, rsp_trace_length
//
// A commit that does not close a trace is accepted by the front end, and its result is
// queued at one per cycle by the table engine while a result slot is free; so is a trace
// that is too long. A closing commit that needs a table lookup holds off further
// transactions (full stays high) until the table engine is done: it walks the table
// entries, compares the stored PCs of each entry whose hash and length agree one PC at
// a time, and copies the PCs one at a time when a new entry is filled. The registered
// reads of the stored PC memory and the open trace buffer set that pace.
// Reset is synchronous and clears the valid bits at once; there is no clearing
// pass. Two result slots let the engine run ahead of a stalled consumer.
module hot_trace_frequency_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [htft_pkg::PcW-1:0]      req_pc,
   input  logic                          req_is_control,
   input  logic [htft_pkg::PcW-1:0]      req_target,
   output logic                          empty,
   input  logic                          pop,
   output logic [htft_pkg::OutcomeW-1:0] rsp_outcome,
   output logic [htft_pkg::IndexW-1:0]   rsp_entry_index,
   output logic [htft_pkg::CountW-1:0]   rsp_trace_count,
   output logic [htft_pkg::LengthW-1:0]  rsp_trace_length
);
   import htft_pkg::*;

   // Commands from the front end; each accepted transaction gives exactly one.
   cmd_type          cmd_wdata, cmd_rdata;
   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;

   // The engine reads the open trace buffer and hands it back when finished.
   trace_rd_req_type trace_req;
   logic [PcW-1:0]   trace_data;

   htft_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_pc         (req_pc),
      .req_is_control (req_is_control),
      .req_target     (req_target),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_wdata),
      .cmd_full       (cmd_full),
      .rd_req         (trace_req),
      .rd_data        (trace_data)
   );

   htft_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .cmd_in  (cmd_wdata),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .cmd_out (cmd_rdata),
      .empty   (cmd_empty)
   );

   htft_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_head         (cmd_rdata),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .rd_req           (trace_req),
      .rd_data          (trace_data),
      .pop              (pop),
      .empty            (empty),
      .rsp_outcome      (rsp_outcome),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_trace_count  (rsp_trace_count),
      .rsp_trace_length (rsp_trace_length)
   );
endmodule

@@ rtl/htft_front.sv @@
// Front end: accepts commits, builds the open trace and classifies each commit.
module htft_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [htft_pkg::PcW-1:0]  req_pc,
   input  logic                      req_is_control,
   input  logic [htft_pkg::PcW-1:0]  req_target,
   output logic                      cmd_push,
   output htft_pkg::cmd_type         cmd_data,
   input  logic                      cmd_full,
   input  htft_pkg::trace_rd_req_type rd_req,
   output logic [htft_pkg::PcW-1:0]  rd_data
);
   import htft_pkg::*;

   logic [LenW-1:0] len_ff, len_in;
   logic [PcW-1:0]  hash_ff, hash_in;
   logic            ovf_ff, ovf_in;
   logic            busy_ff, busy_in;
   logic [PcW-1:0]  open_pcs [MaxTraceLen];
   logic [PcW-1:0]  rd_data_ff;

   logic            accept, has_room, closes;
   logic [LenW-1:0] new_len;
   logic            new_ovf;
   logic [PcW-1:0]  new_hash;

   assign full     = busy_ff || cmd_full;
   assign accept   = push && !full;
   assign has_room = len_ff < LenW'(MaxTraceLen);
   assign new_len  = has_room ? len_ff + LenW'(1) : len_ff;
   assign new_ovf  = ovf_ff || !has_room;
   assign new_hash = hash_ff ^ req_pc;
   assign closes   = req_is_control && (req_target < req_pc);
   assign rd_data  = rd_data_ff;
   assign cmd_push = accept;

   always_comb begin
      cmd_data.hash   = new_hash;
      cmd_data.length = new_len;
      if (!closes) begin
         cmd_data.kind = CMD_OPEN;
      end else if (new_ovf) begin
         cmd_data.kind = CMD_LONG;
      end else begin
         cmd_data.kind = CMD_LOOKUP;
      end
   end

   always_comb begin
      len_in  = len_ff;
      hash_in = hash_ff;
      ovf_in  = ovf_ff;
      busy_in = busy_ff;
      if (rd_req.free_trace) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (closes) begin
            len_in  = '0;
            hash_in = '0;
            ovf_in  = 1'b0;
            busy_in = (cmd_data.kind == CMD_LOOKUP);
         end else begin
            len_in  = new_len;
            hash_in = new_hash;
            ovf_in  = new_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         hash_ff <= '0;
         ovf_ff  <= 1'b0;
         busy_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         hash_ff <= hash_in;
         ovf_ff  <= ovf_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && has_room) begin
         open_pcs[len_ff[PosW-1:0]] <= req_pc;
      end
      rd_data_ff <= open_pcs[rd_req.addr];
   end
endmodule

@@ rtl/htft_cmd_queue.sv @@
// Two-entry command queue between the front end and the table engine.
module htft_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  htft_pkg::cmd_type cmd_in,
   output logic              full,
   input  logic              pop,
   output htft_pkg::cmd_type cmd_out,
   output logic              empty
);
   import htft_pkg::*;

   cmd_type    slots [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign cmd_out = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= cmd_in;
      end
   end
endmodule

@@ rtl/htft_back.sv @@
// Table engine: walks the entries, compares and stores traces, queues results.
module htft_back (
   input  logic                          clock,
   input  logic                          reset,
   input  htft_pkg::cmd_type             cmd_head,
   input  logic                          cmd_empty,
   output logic                          cmd_pop,
   output htft_pkg::trace_rd_req_type    rd_req,
   input  logic [htft_pkg::PcW-1:0]      rd_data,
   input  logic                          pop,
   output logic                          empty,
   output logic [htft_pkg::OutcomeW-1:0] rsp_outcome,
   output logic [htft_pkg::IndexW-1:0]   rsp_entry_index,
   output logic [htft_pkg::CountW-1:0]   rsp_trace_count,
   output logic [htft_pkg::LengthW-1:0]  rsp_trace_length
);
   import htft_pkg::*;

   typedef enum logic [6:0] {
      B_IDLE = 7'b0000001,
      B_HREQ = 7'b0000010,
      B_HCHK = 7'b0000100,
      B_PREQ = 7'b0001000,
      B_PCHK = 7'b0010000,
      B_CREQ = 7'b0100000,
      B_CWR  = 7'b1000000
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [IdxW-1:0]         e_ff, e_in;
   logic [PosW-1:0]         i_ff, i_in;
   logic                    free_found_ff, free_found_in;
   logic [IdxW-1:0]         free_idx_ff, free_idx_in;
   logic [TableEntries-1:0] valid_ff, valid_in;

   header_type              hdr_mem [TableEntries];
   header_type              hdr_q;
   logic                    hdr_we;
   logic [IdxW-1:0]         hdr_waddr;
   header_type              hdr_wdata;

   logic [PcW-1:0]          store_mem [StoreDepth];
   logic [PcW-1:0]          store_q;
   logic                    st_we;
   logic [StoreAddrW-1:0]   st_raddr, st_waddr;

   result_type              res_mem [2];
   logic                    res_wr_ff, res_wr_in;
   logic                    res_rd_ff, res_rd_in;
   logic [1:0]              res_cnt_ff, res_cnt_in;
   logic                    out_push, out_pop, out_full;
   result_type              out_data, res_head;

   logic                    last_pos, last_e, hdr_hit, advance, free_here;
   logic [CountW-1:0]       sat_count;

   assign last_pos  = (LenW'(i_ff) == cmd_ff.length - LenW'(1));
   assign last_e    = (e_ff == IdxW'(TableEntries - 1));
   assign hdr_hit   = valid_ff[e_ff] && (hdr_q.hash == cmd_ff.hash)
                      && (hdr_q.length == cmd_ff.length);
   assign sat_count = (&hdr_q.count) ? hdr_q.count : hdr_q.count + CountW'(1);
   assign free_here = (state_ff == B_HCHK) && !valid_ff[e_ff];
   assign st_raddr  = StoreAddrW'(e_ff) * StoreAddrW'(MaxTraceLen) + StoreAddrW'(i_ff);
   assign st_waddr  = StoreAddrW'(free_idx_ff) * StoreAddrW'(MaxTraceLen)
                      + StoreAddrW'(i_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      e_in          = e_ff;
      i_in          = i_ff;
      free_found_in = free_found_ff || free_here;
      free_idx_in   = free_found_ff ? free_idx_ff : e_ff;
      valid_in      = valid_ff;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_data      = '0;
      hdr_we        = 1'b0;
      hdr_waddr     = e_ff;
      hdr_wdata     = '0;
      st_we         = 1'b0;
      rd_req.addr       = i_ff;
      rd_req.free_trace = 1'b0;
      advance       = 1'b0;

      unique case (state_ff)
         B_IDLE: begin
            if (!cmd_empty && !out_full) begin
               cmd_pop = 1'b1;
               case (cmd_head.kind)
                  CMD_OPEN: begin
                     out_push         = 1'b1;
                     out_data.outcome = OUT_OPEN;
                  end
                  CMD_LONG: begin
                     out_push              = 1'b1;
                     out_data.outcome      = OUT_LONG;
                     out_data.trace_length = LengthW'(cmd_head.length);
                  end
                  default: begin
                     cmd_in        = cmd_head;
                     e_in          = '0;
                     free_found_in = 1'b0;
                     state_in      = B_HREQ;
                  end
               endcase
            end
         end
         B_HREQ: state_in = B_HCHK;
         B_HCHK: begin
            if (hdr_hit) begin
               i_in     = '0;
               state_in = B_PREQ;
            end else begin
               advance = 1'b1;
            end
         end
         B_PREQ: state_in = B_PCHK;
         B_PCHK: begin
            if (store_q == rd_data) begin
               if (last_pos) begin
                  hdr_we                = 1'b1;
                  hdr_waddr             = e_ff;
                  hdr_wdata             = '{hash: cmd_ff.hash, length: cmd_ff.length,
                                            count: sat_count};
                  out_push              = 1'b1;
                  out_data.outcome      = OUT_MATCH;
                  out_data.entry_index  = IndexW'(e_ff);
                  out_data.trace_count  = sat_count;
                  out_data.trace_length = LengthW'(cmd_ff.length);
                  rd_req.free_trace     = 1'b1;
                  state_in              = B_IDLE;
               end else begin
                  i_in     = i_ff + PosW'(1);
                  state_in = B_PREQ;
               end
            end else begin
               advance = 1'b1;
            end
         end
         B_CREQ: state_in = B_CWR;
         B_CWR: begin
            st_we = 1'b1;
            if (last_pos) begin
               hdr_we                 = 1'b1;
               hdr_waddr              = free_idx_ff;
               hdr_wdata              = '{hash: cmd_ff.hash, length: cmd_ff.length,
                                          count: CountW'(1)};
               valid_in[free_idx_ff]  = 1'b1;
               out_push               = 1'b1;
               out_data.outcome       = OUT_NEW;
               out_data.entry_index   = IndexW'(free_idx_ff);
               out_data.trace_count   = CountW'(1);
               out_data.trace_length  = LengthW'(cmd_ff.length);
               rd_req.free_trace      = 1'b1;
               state_in               = B_IDLE;
            end else begin
               i_in     = i_ff + PosW'(1);
               state_in = B_CREQ;
            end
         end
         default: state_in = B_IDLE;
      endcase

      // Move on to the next entry, or settle a miss after the last one.
      if (advance) begin
         if (last_e) begin
            if (free_found_in) begin
               i_in     = '0;
               state_in = B_CREQ;
            end else begin
               out_push              = 1'b1;
               out_data.outcome      = OUT_FULL;
               out_data.trace_length = LengthW'(cmd_ff.length);
               rd_req.free_trace     = 1'b1;
               state_in              = B_IDLE;
            end
         end else begin
            e_in     = e_ff + IdxW'(1);
            state_in = B_HREQ;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         free_found_ff <= free_found_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      e_ff        <= e_in;
      i_ff        <= i_in;
      free_idx_ff <= free_idx_in;
   end

   always_ff @(posedge clock) begin
      if (hdr_we) begin
         hdr_mem[hdr_waddr] <= hdr_wdata;
      end
      hdr_q <= hdr_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= rd_data;
      end
      store_q <= store_mem[st_raddr];
   end

   assign out_full = (res_cnt_ff == 2'd2);
   assign empty    = (res_cnt_ff == 2'd0);
   assign out_pop  = pop && !empty;
   assign res_head = res_mem[res_rd_ff];

   assign rsp_outcome      = res_head.outcome;
   assign rsp_entry_index  = res_head.entry_index;
   assign rsp_trace_count  = res_head.trace_count;
   assign rsp_trace_length = res_head.trace_length;

   always_comb begin
      res_wr_in  = res_wr_ff ^ out_push;
      res_rd_in  = res_rd_ff ^ out_pop;
      res_cnt_in = res_cnt_ff + 2'(out_push) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff  <= 1'b0;
         res_rd_ff  <= 1'b0;
         res_cnt_ff <= '0;
      end else begin
         res_wr_ff  <= res_wr_in;
         res_rd_ff  <= res_rd_in;
         res_cnt_ff <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         res_mem[res_wr_ff] <= out_data;
      end
   end
endmodule

@@ rtl/htft_checker.sv @@
// Port-level checker for the hot trace frequency table, bound to the top level.
`include "hot_trace_frequency_table_defines.svh"

module htft_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          pop,
   input logic                          empty,
   input logic [htft_pkg::OutcomeW-1:0] rsp_outcome,
   input logic [htft_pkg::IndexW-1:0]   rsp_entry_index,
   input logic [htft_pkg::CountW-1:0]   rsp_trace_count,
   input logic [htft_pkg::LengthW-1:0]  rsp_trace_length
);
   import htft_pkg::*;

   `HTFT_ASSERT_NEXT(a_rsp_hold, clock, reset, (!empty && !pop),
      (!empty && $stable(rsp_outcome) && $stable(rsp_trace_count)))
   `HTFT_ASSERT_NOW(a_open_zero, clock, reset, (!empty && rsp_outcome == OUT_OPEN),
      (rsp_entry_index == '0 && rsp_trace_count == '0 && rsp_trace_length == '0))
   `HTFT_ASSERT_NOW(a_new_count, clock, reset, (!empty && rsp_outcome == OUT_NEW),
      (rsp_trace_count == CountW'(1) && rsp_trace_length != '0))
   `HTFT_ASSERT_NOW(a_long_len, clock, reset, (!empty && rsp_outcome == OUT_LONG),
      (rsp_trace_length == LengthW'(MaxTraceLen) && rsp_trace_count == '0))
endmodule

bind hot_trace_frequency_table htft_checker u_htft_checker (.*);
